// ===== design/sga_pkg.sv =====
package sga_pkg;

  localparam int MAX_BODIES_DEF = 64;
  localparam int QUEUE_DEPTH = 2;

  // datapath widths
  localparam int DW    = 33;   // coordinate difference
  localparam int R2W   = 67;   // |d|^2 + eps^2, Q35.32
  localparam int MULW  = 100;  // shift-add multiplier accumulator
  localparam int MBW   = 35;   // multiplier operand consumed one bit a cycle
  localparam int DENW  = 99;   // r2 * r, Q51.48
  localparam int GMW   = 64;   // G * m, Q32.32
  localparam int NUMW  = 112;  // G*m*|d| << 16
  localparam int REMW  = 100;  // divider remainder
  localparam int QW    = 42;   // divider quotient window
  localparam int CAPW  = 41;
  localparam int ACCW  = 48;   // per-body acceleration sum
  localparam int DIVCW = 7;
  localparam logic [CAPW-1:0] TERM_CAP = CAPW'(64'h100_0000_0000);

  localparam int CFG_IDXW = 1;
  localparam logic [CFG_IDXW-1:0] CFG_SOFTENING_SQ = 1'b0;
  localparam logic [CFG_IDXW-1:0] CFG_GRAV_CONST   = 1'b1;
  localparam logic [31:0] SOFTENING_SQ_RST = 32'd2621;
  localparam logic [31:0] GRAV_CONST_RST   = 32'd65536;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        body_mass;
    logic               last_body;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic [5:0]         body_index;
    logic               last_result;
  } out_item_t;

  typedef enum logic [4:0] {
    BK_IDLE, BK_RDI, BK_LDI, BK_RDJ, BK_LDJ, BK_SQ_LD, BK_SQ_RUN, BK_EPS,
    BK_SQRT_LD, BK_SQRT_RUN, BK_DEN_LD, BK_DEN_RUN, BK_GM_LD, BK_GM_RUN,
    BK_NUM_LD, BK_NUM_RUN, BK_DIV_LD, BK_DIV_RUN, BK_ACC, BK_OUT
  } back_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] hi;
    logic signed [ACCW-1:0] lo;
    hi = ACCW'(64'sd2147483647);
    lo = -ACCW'(64'sd2147483648);
    if (v > hi) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== design/sga_ram.sv =====
module sga_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sga_queue.sv =====
module sga_queue #(
  parameter int WIDTH = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  localparam int PW = $clog2(sga_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0] entry_r [sga_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW:0]      level_r;

  assign valid = (level_r != '0);
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && valid) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      level_r <= level_r + (PW+1)'(push) - (PW+1)'(pop && valid);
    end
  end

endmodule

// ===== design/sga_front.sv =====
module sga_front #(
  parameter int MAX_BODIES = sga_pkg::MAX_BODIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  sga_pkg::in_item_t               item,
  output logic                            ram_we,
  output logic [$clog2(MAX_BODIES)-1:0]   ram_waddr,
  output logic [127:0]                    ram_wdata,
  output logic                            job_push,
  output logic [$clog2(MAX_BODIES+1)-1:0] job_count
);

  localparam int AW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          room;

  assign room      = (count_r < CW'(MAX_BODIES));
  assign ram_we    = accept && room;
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = {item.pos_x, item.pos_y, item.pos_z, item.body_mass};
  assign count_nxt = room ? count_r + 1'b1 : count_r;
  assign job_push  = accept && item.last_body;
  assign job_count = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= item.last_body ? '0 : count_nxt;
    end
  end

endmodule

// ===== design/sga_back.sv =====
module sga_back #(
  parameter int MAX_BODIES = sga_pkg::MAX_BODIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [31:0]                     softening_sq,
  input  logic [31:0]                     grav_const,
  input  logic                            job_valid,
  input  logic [$clog2(MAX_BODIES+1)-1:0] job_count,
  output logic                            job_pop,
  output logic [$clog2(MAX_BODIES)-1:0]   ram_raddr,
  input  logic [127:0]                    ram_rdata,
  output logic                            active,
  output logic                            out_strobe,
  output sga_pkg::out_item_t              out_data
);

  localparam int AW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);

  sga_pkg::back_state_t state_r, state_nxt;

  logic [CW-1:0] n_r, i_r, j_r;
  logic [1:0]    k_r;
  logic [31:0]   pix_r, piy_r, piz_r, mj_r;
  logic signed [sga_pkg::DW-1:0] d_r [3];
  logic [sga_pkg::R2W-1:0]  r2_r, op_r, res_r, one_r;
  logic [sga_pkg::MULW-1:0] mul_a_r, mul_acc_r;
  logic [sga_pkg::MBW-1:0]  mul_b_r;
  logic [sga_pkg::DENW-1:0] den_r;
  logic [sga_pkg::GMW-1:0]  gm_r;
  logic [sga_pkg::NUMW-1:0] num_r;
  logic [sga_pkg::REMW-1:0] rem_r;
  logic [sga_pkg::QW-1:0]   q_r;
  logic                     qovf_r;
  logic [sga_pkg::DIVCW-1:0] div_cnt_r;
  logic signed [sga_pkg::ACCW-1:0] ax_r, ay_r, az_r;
  logic                     out_strobe_r;
  sga_pkg::out_item_t       out_data_r;

  logic signed [sga_pkg::DW-1:0] d_sel;
  logic [sga_pkg::DW-1:0]        d_mag;
  logic [sga_pkg::R2W-1:0]       sq_t;
  logic [sga_pkg::REMW-1:0]      rem_sh;
  logic                          div_ge;
  logic [sga_pkg::CAPW-1:0]      term_mag;
  logic signed [sga_pkg::ACCW-1:0] term;
  logic                          mul_done;

  assign d_sel    = d_r[k_r];
  assign d_mag    = d_sel[sga_pkg::DW-1] ? sga_pkg::DW'(-d_sel) : sga_pkg::DW'(d_sel);
  assign sq_t     = res_r + one_r;
  assign rem_sh   = {rem_r[sga_pkg::REMW-2:0], num_r[sga_pkg::NUMW-1]};
  assign div_ge   = (rem_sh >= sga_pkg::REMW'(den_r));
  assign mul_done = (mul_b_r == '0);
  assign term_mag = (qovf_r || (q_r > sga_pkg::QW'(sga_pkg::TERM_CAP))) ?
                    sga_pkg::TERM_CAP : q_r[sga_pkg::CAPW-1:0];
  assign term     = d_sel[sga_pkg::DW-1] ? -$signed(sga_pkg::ACCW'(term_mag)) :
                    $signed(sga_pkg::ACCW'(term_mag));

  assign active     = (state_r != sga_pkg::BK_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sga_pkg::BK_IDLE:     if (job_valid) state_nxt = sga_pkg::BK_RDI;
      sga_pkg::BK_RDI:      state_nxt = sga_pkg::BK_LDI;
      sga_pkg::BK_LDI:      state_nxt = sga_pkg::BK_RDJ;
      sga_pkg::BK_RDJ: begin
        if (j_r == n_r) begin
          state_nxt = sga_pkg::BK_OUT;
        end else if (j_r != i_r) begin
          state_nxt = sga_pkg::BK_LDJ;
        end
      end
      sga_pkg::BK_LDJ:      state_nxt = sga_pkg::BK_SQ_LD;
      sga_pkg::BK_SQ_LD:    state_nxt = sga_pkg::BK_SQ_RUN;
      sga_pkg::BK_SQ_RUN: begin
        if (mul_done) begin
          state_nxt = (k_r == 2'd2) ? sga_pkg::BK_EPS : sga_pkg::BK_SQ_LD;
        end
      end
      sga_pkg::BK_EPS:      state_nxt = sga_pkg::BK_SQRT_LD;
      sga_pkg::BK_SQRT_LD:  state_nxt = (r2_r == '0) ? sga_pkg::BK_RDJ : sga_pkg::BK_SQRT_RUN;
      sga_pkg::BK_SQRT_RUN: if (one_r == '0) state_nxt = sga_pkg::BK_DEN_LD;
      sga_pkg::BK_DEN_LD:   state_nxt = sga_pkg::BK_DEN_RUN;
      sga_pkg::BK_DEN_RUN:  if (mul_done) state_nxt = sga_pkg::BK_GM_LD;
      sga_pkg::BK_GM_LD:    state_nxt = sga_pkg::BK_GM_RUN;
      sga_pkg::BK_GM_RUN:   if (mul_done) state_nxt = sga_pkg::BK_NUM_LD;
      sga_pkg::BK_NUM_LD:   state_nxt = sga_pkg::BK_NUM_RUN;
      sga_pkg::BK_NUM_RUN:  if (mul_done) state_nxt = sga_pkg::BK_DIV_LD;
      sga_pkg::BK_DIV_LD:   state_nxt = sga_pkg::BK_DIV_RUN;
      sga_pkg::BK_DIV_RUN:  if (div_cnt_r == '0) state_nxt = sga_pkg::BK_ACC;
      sga_pkg::BK_ACC:      state_nxt = (k_r == 2'd2) ? sga_pkg::BK_RDJ : sga_pkg::BK_NUM_LD;
      sga_pkg::BK_OUT:      state_nxt = (i_r + 1'b1 == n_r) ? sga_pkg::BK_IDLE : sga_pkg::BK_RDI;
      default:              state_nxt = sga_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_pop   = (state_r == sga_pkg::BK_IDLE) && job_valid;
    ram_raddr = (state_r == sga_pkg::BK_RDI) ? i_r[AW-1:0] : j_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sga_pkg::BK_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == sga_pkg::BK_OUT);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      sga_pkg::BK_IDLE: begin
        n_r <= job_count;
        i_r <= '0;
      end
      sga_pkg::BK_LDI: begin
        pix_r <= ram_rdata[127:96];
        piy_r <= ram_rdata[95:64];
        piz_r <= ram_rdata[63:32];
        j_r   <= '0;
        ax_r  <= '0;
        ay_r  <= '0;
        az_r  <= '0;
      end
      sga_pkg::BK_RDJ: begin
        if (j_r == i_r && j_r != n_r) begin
          j_r <= j_r + 1'b1;
        end
      end
      sga_pkg::BK_LDJ: begin
        d_r[0] <= $signed({ram_rdata[127], ram_rdata[127:96]}) - $signed({pix_r[31], pix_r});
        d_r[1] <= $signed({ram_rdata[95], ram_rdata[95:64]}) - $signed({piy_r[31], piy_r});
        d_r[2] <= $signed({ram_rdata[63], ram_rdata[63:32]}) - $signed({piz_r[31], piz_r});
        mj_r   <= ram_rdata[31:0];
        r2_r   <= '0;
        k_r    <= '0;
      end
      sga_pkg::BK_SQ_LD: begin
        mul_a_r   <= sga_pkg::MULW'(d_mag);
        mul_b_r   <= sga_pkg::MBW'(d_mag);
        mul_acc_r <= '0;
      end
      // multiplicand for G*m*|d| comes from gm
      sga_pkg::BK_NUM_LD: begin
        mul_a_r   <= sga_pkg::MULW'(gm_r);
        mul_b_r   <= sga_pkg::MBW'(d_mag);
        mul_acc_r <= '0;
      end
      sga_pkg::BK_DEN_LD: begin
        mul_a_r   <= sga_pkg::MULW'(r2_r);
        mul_b_r   <= res_r[sga_pkg::MBW-1:0];
        mul_acc_r <= '0;
      end
      sga_pkg::BK_GM_LD: begin
        mul_a_r   <= sga_pkg::MULW'(grav_const);
        mul_b_r   <= sga_pkg::MBW'(mj_r);
        mul_acc_r <= '0;
      end
      sga_pkg::BK_EPS: begin
        r2_r <= r2_r + sga_pkg::R2W'({softening_sq, 16'h0000});
      end
      sga_pkg::BK_SQRT_LD: begin
        op_r  <= r2_r;
        res_r <= '0;
        one_r <= sga_pkg::R2W'(1) << (sga_pkg::R2W - 1);
        if (r2_r == '0) begin
          j_r <= j_r + 1'b1;
        end
      end
      sga_pkg::BK_SQRT_RUN: begin
        if (one_r != '0) begin
          if (op_r >= sq_t) begin
            op_r  <= op_r - sq_t;
            res_r <= (res_r >> 1) + one_r;
          end else begin
            res_r <= res_r >> 1;
          end
          one_r <= one_r >> 2;
        end
      end
      sga_pkg::BK_DIV_LD: begin
        rem_r     <= '0;
        q_r       <= '0;
        qovf_r    <= 1'b0;
        div_cnt_r <= sga_pkg::DIVCW'(sga_pkg::NUMW);
      end
      sga_pkg::BK_DIV_RUN: begin
        if (div_cnt_r != '0) begin
          rem_r     <= div_ge ? rem_sh - sga_pkg::REMW'(den_r) : rem_sh;
          q_r       <= {q_r[sga_pkg::QW-2:0], div_ge};
          qovf_r    <= qovf_r | q_r[sga_pkg::QW-1];
          num_r     <= num_r << 1;
          div_cnt_r <= div_cnt_r - 1'b1;
        end
      end
      sga_pkg::BK_ACC: begin
        case (k_r)
          2'd0:    ax_r <= ax_r + term;
          2'd1:    ay_r <= ay_r + term;
          default: az_r <= az_r + term;
        endcase
        if (k_r == 2'd2) begin
          j_r <= j_r + 1'b1;
        end
        k_r <= k_r + 1'b1;
      end
      sga_pkg::BK_OUT: begin
        out_data_r.acc_x       <= sga_pkg::sat32(ax_r);
        out_data_r.acc_y       <= sga_pkg::sat32(ay_r);
        out_data_r.acc_z       <= sga_pkg::sat32(az_r);
        out_data_r.body_index  <= 6'(i_r);
        out_data_r.last_result <= (i_r + 1'b1 == n_r);
        i_r <= i_r + 1'b1;
      end
      default: begin
      end
    endcase

    // shared shift-add multiplier: one operand bit a cycle
    if (state_r == sga_pkg::BK_SQ_RUN || state_r == sga_pkg::BK_DEN_RUN ||
        state_r == sga_pkg::BK_GM_RUN || state_r == sga_pkg::BK_NUM_RUN) begin
      if (!mul_done) begin
        if (mul_b_r[0]) begin
          mul_acc_r <= mul_acc_r + mul_a_r;
        end
        mul_a_r <= mul_a_r << 1;
        mul_b_r <= mul_b_r >> 1;
      end else begin
        case (state_r)
          sga_pkg::BK_SQ_RUN: begin
            r2_r <= r2_r + mul_acc_r[sga_pkg::R2W-1:0];
            k_r  <= k_r + 1'b1;
          end
          sga_pkg::BK_DEN_RUN: den_r <= mul_acc_r[sga_pkg::DENW-1:0];
          sga_pkg::BK_GM_RUN: begin
            gm_r <= mul_acc_r[sga_pkg::GMW-1:0];
            k_r  <= '0;
          end
          default: num_r <= {mul_acc_r[sga_pkg::NUMW-17:0], 16'h0000};
        endcase
      end
    end
  end

endmodule

// ===== design/softened_gravity_acceleration.sv =====
// Direct-sum gravitational acceleration with Plummer softening, signed
// Q16.16. Load bodies one transaction at a time with start; the transaction
// whose last_body is set closes the set and launches the computation, after
// which busy stays high until the last result is issued (busy falls in the
// cycle that carries the final strobe). One result per body leaves in load
// order on out_strobe for a single cycle, and the receiver cannot stall it,
// so capture every strobe. Bodies beyond MAX_BODIES are dropped. Loading
// takes one body per cycle while busy is low. The computation runs on a
// single sequential pair unit (shift-add multiplier, bit-serial square root
// and restoring divider); the time a body pair takes depends on operand
// magnitudes, the three 112-step divisions being the bulk of it. Write
// configuration only while busy is low.
module softened_gravity_acceleration #(
  parameter int MAX_BODIES = sga_pkg::MAX_BODIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  sga_pkg::in_item_t                in_data,
  output logic                             out_strobe,
  output sga_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [sga_pkg::CFG_IDXW-1:0]     cfg_index,
  input  logic [31:0]                      cfg_wdata
);

  localparam int AW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);

  logic [31:0]   softening_sq_r;
  logic [31:0]   grav_const_r;
  logic          accept;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [127:0]  ram_wdata;
  logic [127:0]  ram_rdata;
  logic          job_push;
  logic          job_pop;
  logic          job_valid;
  logic [CW-1:0] job_count;
  logic [CW-1:0] job_head;
  logic          back_active;

  // hold off new bodies while a set is queued or being worked on
  assign busy   = job_valid || back_active;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      softening_sq_r <= sga_pkg::SOFTENING_SQ_RST;
      grav_const_r   <= sga_pkg::GRAV_CONST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sga_pkg::CFG_SOFTENING_SQ: softening_sq_r <= cfg_wdata;
        sga_pkg::CFG_GRAV_CONST:   grav_const_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  sga_front #(.MAX_BODIES(MAX_BODIES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .job_push  (job_push),
    .job_count (job_count)
  );

  // body store: x, y, z, mass side by side
  sga_ram #(.WIDTH(128), .DEPTH(MAX_BODIES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // closed sets wait here for the pair unit
  sga_queue #(.WIDTH(CW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_count),
    .pop       (job_pop),
    .valid     (job_valid),
    .head      (job_head)
  );

  sga_back #(.MAX_BODIES(MAX_BODIES)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .softening_sq (softening_sq_r),
    .grav_const   (grav_const_r),
    .job_valid    (job_valid),
    .job_count    (job_head),
    .job_pop      (job_pop),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .active       (back_active),
    .out_strobe   (out_strobe),
    .out_data     (out_data)
  );

endmodule
